// ----- rtl/gbc_pkg.sv -----
// Shared types and constants of the gather block coalescing buffer.
// Holds the item, result and command structs and the request codes.
// No dependencies; every other file of the block imports it.
package gbc_pkg;

    // Field widths fixed by the item and result formats.
    localparam int ADDR_W        = 64;
    localparam int TAG_W         = 8;
    localparam int ISSUE_BLOCK_W = 56;
    localparam int SLOT_W        = 6;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH   = 2;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        OP_LANE  = 2'd0,
        OP_ISSUE = 2'd1,
        OP_RESP  = 2'd2,
        OP_START = 2'd3
    } gbc_op_t;

    // One input item.
    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] addr;
        logic [TAG_W-1:0]  gather_tag;
    } gbc_in_t;

    // One result item.
    typedef struct packed {
        logic                     issue_valid;
        logic [ISSUE_BLOCK_W-1:0] issue_block;
        logic [SLOT_W-1:0]        issue_slot;
        logic                     all_issued;
        logic                     gather_done;
        logic [TAG_W-1:0]         done_tag;
        logic                     busy_res;
        logic                     dropped;
    } gbc_out_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        gbc_op_t           op;
        logic [ADDR_W-1:0] block;
        logic [TAG_W-1:0]  tag;
    } gbc_cmd_t;

endpackage

// ----- rtl/gbc_if.sv -----
// Valid/ready stream interfaces for the input items and the results.
// Depends on gbc_pkg for the payload structs.
interface gbc_in_if;
    import gbc_pkg::*;

    logic    valid;
    logic    ready;
    gbc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gbc_out_if;
    import gbc_pkg::*;

    logic     valid;
    logic     ready;
    gbc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/gbc_front.sv -----
// Front end: accepts input items, decodes the request and forms the block number.
// Classified commands wait in a short queue for the back end.
// Depends on gbc_pkg and gbc_in_if.
module gbc_front #(
    parameter int BLOCK_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    gbc_in_if.sink            item,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output gbc_pkg::gbc_cmd_t cmd
);
    import gbc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    gbc_cmd_t         q_data_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   q_count_reg;
    gbc_cmd_t         cmd_new;
    logic             push;
    logic             pop;

    // Classify the incoming item.
    always_comb
    begin
        cmd_new.op    = gbc_op_t'(item.data.req_type);
        cmd_new.block = item.data.addr >> BLOCK_BITS;
        cmd_new.tag   = item.data.gather_tag;
    end

    assign item.ready = (q_count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign cmd_valid  = (q_count_reg != '0);
    assign cmd        = q_data_reg[rd_ptr_reg];
    assign push       = item.valid && item.ready;
    assign pop        = cmd_valid && cmd_ready;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[wr_ptr_reg] <= cmd_new;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                q_count_reg <= q_count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                q_count_reg <= q_count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/gbc_back.sv -----
// Back end: block table with a parallel compare array, issue memory,
// answered bits, counters and the result register.
// Depends on gbc_pkg and gbc_out_if.
module gbc_back #(
    parameter int ENTRIES    = 64,
    parameter int BLOCK_BITS = 8,
    parameter int TAG_BITS   = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  gbc_pkg::gbc_cmd_t cmd,
    gbc_out_if.source         result
);
    import gbc_pkg::*;

    localparam int BW    = ADDR_W - BLOCK_BITS;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EXEC
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    gbc_cmd_t           cur_reg;

    // Block table: compare copy in flops, issue copy in a memory.
    logic [BW-1:0]      cam_reg [ENTRIES];
    logic [BW-1:0]      mem [ENTRIES];
    logic [BW-1:0]      rd_data_reg;
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] match_next;

    logic [ENTRIES-1:0] answered_reg;
    logic [ENTRIES-1:0] answered_next;
    logic [CNT_W-1:0]   stored_count_reg;
    logic [CNT_W-1:0]   stored_count_next;
    logic [CNT_W-1:0]   issue_ptr_reg;
    logic [CNT_W-1:0]   issue_ptr_next;
    logic               busy_reg;
    logic               busy_next;
    logic               finished_reg;
    logic               finished_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;

    logic               out_valid_reg;
    gbc_out_t           out_data_reg;
    gbc_out_t           res;

    logic [ENTRIES-1:0] stored_mask;
    logic [ENTRIES-1:0] issued_mask;
    logic [ENTRIES-1:0] answered_resp;
    logic [BW-1:0]      cur_block;
    logic [IDX_W-1:0]   append_idx;
    logic               hit;
    logic               full;
    logic               append;
    logic               fire;
    logic               cmd_fire;

    assign cur_block  = cur_reg.block[BW-1:0];
    assign append_idx = stored_count_reg[IDX_W-1:0];
    assign hit        = |match_reg;
    assign full       = (stored_count_reg == CNT_W'(ENTRIES));

    // The execute step completes once the result register is free.
    assign fire      = (state_reg == ST_EXEC) && (!out_valid_reg || result.ready);
    assign cmd_ready = (state_reg == ST_IDLE) || fire;
    assign cmd_fire  = cmd_valid && cmd_ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Occupancy masks and the compare of all stored blocks.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            stored_mask[i] = (CNT_W'(i) < stored_count_reg);
            issued_mask[i] = (CNT_W'(i) < issue_ptr_reg);
            match_next[i]  = stored_mask[i] && (cam_reg[i] == cur_block);
        end
    end

    // Execute the current command on the registered match vector.
    always_comb
    begin
        stored_count_next = stored_count_reg;
        issue_ptr_next    = issue_ptr_reg;
        busy_next         = busy_reg;
        finished_next     = finished_reg;
        tag_next          = tag_reg;
        answered_next     = answered_reg;
        answered_resp     = answered_reg | match_reg;
        append            = 1'b0;
        res               = '0;

        unique case (cur_reg.op)
            OP_START:
            begin
                tag_next  = TAG_BITS'(cur_reg.tag);
                busy_next = 1'b1;
            end
            OP_LANE:
            begin
                if (!hit)
                begin
                    if (!full)
                    begin
                        append                    = 1'b1;
                        answered_next[append_idx] = 1'b0;
                        stored_count_next         = stored_count_reg + 1'b1;
                    end
                    else
                    begin
                        res.dropped = 1'b1;
                    end
                end
            end
            OP_ISSUE:
            begin
                if (issue_ptr_reg < stored_count_reg)
                begin
                    res.issue_valid = 1'b1;
                    res.issue_block = ISSUE_BLOCK_W'(rd_data_reg);
                    res.issue_slot  = SLOT_W'(issue_ptr_reg);
                    issue_ptr_next  = issue_ptr_reg + 1'b1;
                    if (issue_ptr_next == stored_count_reg)
                    begin
                        finished_next = 1'b1;
                    end
                end
            end
            OP_RESP:
            begin
                if ((issued_mask & ~answered_resp) == '0)
                begin
                    // Every issued block is answered: report and clear.
                    res.gather_done   = 1'b1;
                    res.done_tag      = TAG_W'(tag_reg);
                    stored_count_next = '0;
                    issue_ptr_next    = '0;
                    busy_next         = 1'b0;
                    finished_next     = 1'b0;
                    tag_next          = '0;
                    answered_next     = '0;
                end
                else
                begin
                    answered_next = answered_resp;
                end
            end
            default:
            begin
            end
        endcase

        res.all_issued = finished_next;
        res.busy_res   = busy_next;
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = cmd_valid ? ST_MATCH : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Table storage, issue memory read and match register.
    always_ff @(posedge clk)
    begin
        if (fire && append)
        begin
            cam_reg[append_idx] <= cur_block;
            mem[append_idx]     <= cur_block;
        end
        rd_data_reg <= mem[issue_ptr_reg[IDX_W-1:0]];
        match_reg   <= match_next;
        if (cmd_fire)
        begin
            cur_reg <= cmd;
        end
    end

    // State, buffer control registers and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stored_count_reg <= '0;
            issue_ptr_reg    <= '0;
            busy_reg         <= 1'b0;
            finished_reg     <= 1'b0;
            tag_reg          <= '0;
            answered_reg     <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                stored_count_reg <= stored_count_next;
                issue_ptr_reg    <= issue_ptr_next;
                busy_reg         <= busy_next;
                finished_reg     <= finished_next;
                tag_reg          <= tag_next;
                answered_reg     <= answered_next;
                out_valid_reg    <= 1'b1;
                out_data_reg     <= res;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The issue pointer never passes the stored count.
    assert property (@(posedge clk) disable iff (!rst_n)
        issue_ptr_reg <= stored_count_reg)
        else $error("issue pointer beyond stored blocks");

    // Answered bits exist only for stored blocks.
    assert property (@(posedge clk) disable iff (!rst_n)
        (answered_reg & ~stored_mask) == '0)
        else $error("answered bit set on an empty slot");

    // Issuing finished implies at least one block went out.
    assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (issue_ptr_reg != '0))
        else $error("issue finished with nothing issued");

    // A completed gather leaves the buffer empty and idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.gather_done) |=> (stored_count_reg == '0) && !busy_reg)
        else $error("buffer not cleared after completion");

endmodule

// ----- rtl/gather_block_coalesce_buffer_core.sv -----
// Gather block coalescing buffer. Lane addresses of one gather load are merged into unique
// blocks of 2^BLOCK_BITS bytes held in a table of ENTRIES slots; issue requests hand the
// blocks out in slot order, memory responses mark matching blocks, and a response that
// leaves every issued block answered reports the gather's tag and empties the table. Every
// accepted item yields exactly one result. Items are handled one at a time in the back end:
// each passes through a match step, which compares the block number against all stored
// blocks in parallel, and an execute step, which updates the table and builds the result;
// the execute step waits until the result register is free. A two-entry command queue and
// the result register let the input keep flowing while a result waits. No clearing pass
// follows reset; the table is governed by its fill count.
// Depends on gbc_pkg, gbc_if, gbc_front and gbc_back.
module gather_block_coalesce_buffer_core #(
    parameter int ENTRIES    = 64,
    parameter int BLOCK_BITS = 8,
    parameter int TAG_BITS   = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    gbc_in_if.sink    item,
    gbc_out_if.source result
);
    import gbc_pkg::*;

    logic     cmd_valid;
    logic     cmd_ready;
    gbc_cmd_t cmd;

    // Accept and classify items.
    gbc_front #(
        .BLOCK_BITS (BLOCK_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Execute commands against the block table.
    gbc_back #(
        .ENTRIES    (ENTRIES),
        .BLOCK_BITS (BLOCK_BITS),
        .TAG_BITS   (TAG_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .result    (result)
    );

endmodule

// ----- tb/sv/gbc_coalesce_check.sv -----
// Checker for the gather block coalescing buffer: watches both streams, predicts each result.
// Depends on gbc_pkg for the item and result structs and on gbc_if for the stream interfaces.
`timescale 1ns / 1ps

module gbc_coalesce_check #(
    parameter int ENTRIES    = 64,
    parameter int BLOCK_BITS = 8,
    parameter int TAG_BITS   = 8
) (
    input  logic clk,
    input  logic rst_n,
    gbc_in_if    item,
    gbc_out_if   result,
    output int   mismatches,
    output int   pending,
    output int   gathers_done,
    output int   blocks_dropped,
    output int   blocks_issued
);
    import gbc_pkg::*;

    localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((1 << TAG_BITS) - 1);

    // Predicted contents of the coalescing table and its control state.
    logic [ADDR_W-1:0]  blk_table [ENTRIES];
    logic [ENTRIES-1:0] answered;
    int                 fill;
    int                 next_issue;
    bit                 busy;
    bit                 issued_all;
    logic [TAG_W-1:0]   gather_id;

    // Results the block still owes, oldest first.
    gbc_out_t owed_results [$];

    int err_total;
    int done_total;
    int drop_total;
    int issue_total;
    int results_seen;

    // Empty the table and return every control flag to its reset value.
    function automatic void clear_table();
        answered   = '0;
        fill       = 0;
        next_issue = 0;
        busy       = 1'b0;
        issued_all = 1'b0;
        gather_id  = '0;
    endfunction

    // Apply one accepted item to the predicted state and build its result.
    function automatic gbc_out_t predict_coalesce(input gbc_in_t it);
        gbc_out_t          r;
        logic [ADDR_W-1:0] blk;
        bit                hit;
        bit                all_answered;
        r   = '0;
        blk = it.addr >> BLOCK_BITS;
        case (gbc_op_t'(it.req_type))
            OP_START:
            begin
                gather_id = it.gather_tag & TAG_MASK;
                busy      = 1'b1;
            end
            OP_LANE:
            begin
                hit = 1'b0;
                for (int i = 0; i < fill; i++)
                    if (blk_table[i] == blk)
                        hit = 1'b1;
                // A new block takes the next free slot, or is lost when the table is full.
                if (!hit)
                begin
                    if (fill < ENTRIES)
                    begin
                        blk_table[fill] = blk;
                        answered[fill]  = 1'b0;
                        fill++;
                    end
                    else
                        r.dropped = 1'b1;
                end
            end
            OP_ISSUE:
            begin
                if (next_issue < fill)
                begin
                    r.issue_valid = 1'b1;
                    r.issue_block = ISSUE_BLOCK_W'(blk_table[next_issue]);
                    r.issue_slot  = SLOT_W'(next_issue);
                    next_issue++;
                    if (next_issue == fill)
                        issued_all = 1'b1;
                end
            end
            default:
            begin
                // A response marks every matching slot; completion needs all issued slots marked.
                for (int i = 0; i < fill; i++)
                    if (blk_table[i] == blk)
                        answered[i] = 1'b1;
                all_answered = 1'b1;
                for (int i = 0; i < next_issue; i++)
                    if (!answered[i])
                        all_answered = 1'b0;
                if (all_answered)
                begin
                    r.gather_done = 1'b1;
                    r.done_tag    = gather_id;
                    clear_table();
                end
            end
        endcase
        r.all_issued = issued_all;
        r.busy_res   = busy;
        return r;
    endfunction

    // Count a failure and describe it while the report budget lasts.
    task automatic report(input string msg);
        if (err_total < 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_total++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v)
            report($sformatf("result %0d field %s expected %h, got %h",
                             results_seen, name, want_v, got_v));
    endtask

    // Predict on every input transfer, compare on every result transfer.
    always @(posedge clk)
    begin : monitor
        gbc_out_t want;
        gbc_out_t got;
        if (!rst_n)
        begin
            clear_table();
            owed_results.delete();
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                want = predict_coalesce(item.data);
                owed_results.push_back(want);
                if (want.dropped)
                    drop_total++;
                if (want.gather_done)
                    done_total++;
                if (want.issue_valid)
                    issue_total++;
            end
            if (result.valid && result.ready)
            begin
                got = result.data;
                if (owed_results.size() == 0)
                    report($sformatf("result %0d arrived with nothing outstanding",
                                     results_seen));
                else
                begin
                    want = owed_results.pop_front();
                    check_field("issue_valid", 64'(want.issue_valid), 64'(got.issue_valid));
                    check_field("issue_block", 64'(want.issue_block), 64'(got.issue_block));
                    check_field("issue_slot",  64'(want.issue_slot),  64'(got.issue_slot));
                    check_field("all_issued",  64'(want.all_issued),  64'(got.all_issued));
                    check_field("gather_done", 64'(want.gather_done), 64'(got.gather_done));
                    check_field("done_tag",    64'(want.done_tag),    64'(got.done_tag));
                    check_field("busy_res",    64'(want.busy_res),    64'(got.busy_res));
                    check_field("dropped",     64'(want.dropped),     64'(got.dropped));
                end
                results_seen++;
            end
        end
        mismatches     <= err_total;
        pending        <= owed_results.size();
        gathers_done   <= done_total;
        blocks_dropped <= drop_total;
        blocks_issued  <= issue_total;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the coalescing buffer testbench: clock, reset, stimulus and the final verdict.
// Depends on gbc_pkg, gbc_if, the block itself and the gbc_coalesce_check checker.
`timescale 1ns / 1ps

module testbench;
    import gbc_pkg::*;

    localparam int ENTRIES      = 64;
    localparam int BLOCK_BITS   = 8;
    localparam int TAG_BITS     = 8;
    localparam int ITEM_TARGET  = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [63:0] LOW_MASK = (64'd1 << BLOCK_BITS) - 64'd1;

    // How a lane address is chosen.
    typedef enum int {
        LANE_REPEAT = 0,
        LANE_NEAR   = 1,
        LANE_FAR    = 2
    } lane_kind_t;

    logic clk = 1'b0;
    logic rst_n;

    gbc_in_if  item_ch ();
    gbc_out_if result_ch ();

    int mismatches;
    int pending;
    int gathers_done;
    int blocks_dropped;
    int blocks_issued;

    int          items_sent;
    int          cycle_count;
    int          gather_count;
    bit          calm;
    logic [63:0] base_addr;
    logic [63:0] lane_blocks [$];

    always #2 clk = ~clk;

    gather_block_coalesce_buffer_core #(
        .ENTRIES    (ENTRIES),
        .BLOCK_BITS (BLOCK_BITS),
        .TAG_BITS   (TAG_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    gbc_coalesce_check #(
        .ENTRIES    (ENTRIES),
        .BLOCK_BITS (BLOCK_BITS),
        .TAG_BITS   (TAG_BITS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item_ch),
        .result         (result_ch),
        .mismatches     (mismatches),
        .pending        (pending),
        .gathers_done   (gathers_done),
        .blocks_dropped (blocks_dropped),
        .blocks_issued  (blocks_issued)
    );

    // The result side stalls at random except during the calm stretch.
    always @(posedge clk)
        result_ch.ready <= calm || ($urandom_range(99) >= 13);

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        return TAG_W'($urandom);
    endfunction

    // Number of lane blocks the table can actually hold.
    function automatic int table_fill();
        return (lane_blocks.size() < ENTRIES) ? lane_blocks.size() : ENTRIES;
    endfunction

    function automatic bit known_block(input logic [63:0] blk);
        foreach (lane_blocks[i])
            if (lane_blocks[i] == blk)
                return 1'b1;
        return 1'b0;
    endfunction

    // Offer one item and hold it until its transfer; valid stays high for a follow-on item.
    task automatic send_item(input gbc_op_t op, input logic [63:0] a,
                             input logic [TAG_W-1:0] t);
        while (!calm && $urandom_range(99) < 13)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= '{req_type: op, addr: a, gather_tag: t};
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_lane(input lane_kind_t kind);
        logic [63:0] a;
        logic [63:0] blk;
        if (kind == LANE_REPEAT && lane_blocks.size() != 0)
        begin
            blk = lane_blocks[$urandom_range(lane_blocks.size() - 1)];
            a   = (blk << BLOCK_BITS) | (rand64() & LOW_MASK);
        end
        else
        begin
            if (kind == LANE_NEAR)
                a = base_addr + (64'($urandom_range(15)) << BLOCK_BITS)
                    + (rand64() & LOW_MASK);
            else
                a = rand64();
            blk = a >> BLOCK_BITS;
            if (!known_block(blk))
                lane_blocks.push_back(blk);
        end
        send_item(OP_LANE, a, rand_tag());
    endtask

    // One gather: start, lane addresses, issues, then responses in random order.
    task automatic run_gather(input bit oversize);
        int               n_lanes;
        int               stored;
        int               issued;
        int               target;
        int               idx;
        logic [63:0]      blk;
        logic [63:0]      owed_blocks [$];
        lane_blocks.delete();
        issued    = 0;
        base_addr = rand64();
        // Most gathers open with a start; the rest let their lanes arrive while idle.
        if ($urandom_range(9) != 0)
            send_item(OP_START, rand64(), rand_tag());
        n_lanes = oversize ? $urandom_range(ENTRIES + 11, ENTRIES + 2) : $urandom_range(16, 1);
        for (int k = 0; k < n_lanes; k++)
        begin
            // Now and then a restart or an early issue lands among the lanes.
            case ($urandom_range(19))
                0: send_item(OP_START, rand64(), rand_tag());
                1, 2:
                begin
                    if (issued < table_fill())
                        issued++;
                    send_item(OP_ISSUE, rand64(), rand_tag());
                end
                default: ;
            endcase
            if (oversize)
                send_lane(LANE_FAR);
            else
                send_lane(lane_kind_t'($urandom_range(2)));
        end
        stored = table_fill();
        if (issued + 1 < stored && $urandom_range(5) == 0)
        begin
            // Stop issuing part way; answering what went out completes the gather.
            target = $urandom_range(stored - 1, issued + 1);
            while (issued < target)
            begin
                send_item(OP_ISSUE, rand64(), rand_tag());
                issued++;
            end
            for (int k = 0; k < issued; k++)
                owed_blocks.push_back(lane_blocks[k]);
        end
        else
        begin
            while (issued < stored)
            begin
                send_item(OP_ISSUE, rand64(), rand_tag());
                issued++;
            end
            repeat ($urandom_range(2))
                send_item(OP_ISSUE, rand64(), rand_tag());
            owed_blocks = lane_blocks;
        end
        // Responses in random order, with stray blocks and repeats mixed in.
        while (owed_blocks.size() != 0)
        begin
            if ($urandom_range(11) == 0)
                send_item(OP_RESP, rand64(), rand_tag());
            idx = $urandom_range(owed_blocks.size() - 1);
            blk = owed_blocks[idx];
            send_item(OP_RESP, (blk << BLOCK_BITS) | (rand64() & LOW_MASK), rand_tag());
            if ($urandom_range(7) != 0)
                owed_blocks.delete(idx);
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.data    <= '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-table response, empty issue, idle lane, restart while busy,
        // address extremes, a hit, issue past the end, a late block and completion.
        send_item(OP_RESP,  64'h0, 8'hA5);
        send_item(OP_ISSUE, '1, '1);
        send_item(OP_LANE,  64'h0, 8'h00);
        send_item(OP_START, 64'h0, 8'hFF);
        send_item(OP_START, '1, 8'h5A);
        send_item(OP_LANE,  '1, 8'h00);
        send_item(OP_LANE,  64'h0000_0000_0000_00FF, 8'h00);
        send_item(OP_ISSUE, 64'h0, 8'h00);
        send_item(OP_ISSUE, 64'h0, 8'h00);
        send_item(OP_ISSUE, 64'h0, 8'h00);
        send_item(OP_LANE,  64'h8000_0000_0000_0100, 8'h00);
        send_item(OP_ISSUE, 64'h0, 8'h00);
        send_item(OP_ISSUE, 64'h0, 8'h00);
        send_item(OP_RESP,  64'hFFFF_FFFF_FFFF_FF37, 8'h00);
        send_item(OP_RESP,  64'h0000_0000_0000_00C3, 8'h00);
        send_item(OP_RESP,  64'h8000_0000_0000_01FF, 8'h00);
        send_item(OP_RESP,  64'h0, 8'h00);

        // Random gathers; the first one overflows the table.
        gather_count = 0;
        while (items_sent < ITEM_TARGET)
        begin
            calm = (items_sent >= 350 && items_sent < 550);
            run_gather(gather_count == 0 || $urandom_range(14) == 0);
            gather_count++;
            if (gather_count == 3 || $urandom_range(9) == 0)
                drain_results();
            // Stray items between gathers, all safe on an empty table.
            if ($urandom_range(3) == 0)
            begin
                repeat ($urandom_range(3, 1))
                begin
                    case ($urandom_range(2))
                        0: send_item(OP_ISSUE, rand64(), rand_tag());
                        1: send_item(OP_START, rand64(), rand_tag());
                        default: send_item(OP_RESP, rand64(), rand_tag());
                    endcase
                end
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d items in %0d random gathers; %0d blocks issued.",
                 items_sent, gather_count, blocks_issued);
        $display("Gathers completed: %0d; lane blocks lost to a full table: %0d.",
                 gathers_done, blocks_dropped);
        if (mismatches == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
